@@ rtl/tlrd_pkg.sv @@
`timescale 1ns / 1ps
package tlrd_pkg;

  // Field widths fixed by the frame format
  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned KIND_W       = 2;
  localparam int unsigned LIMIT_W      = 32;
  localparam int unsigned CFG_INDEX_W  = 8;

  // Default for the stored length width
  localparam int unsigned LENGTH_BITS_DEFAULT = 32;

  // Limit register reset values
  localparam logic [LIMIT_W-1:0] ID_LIMIT_RESET    = LIMIT_W'(16 * 1024 * 1024);
  localparam logic [LIMIT_W-1:0] QUERY_LIMIT_RESET = LIMIT_W'(64 * 1024 * 1024);

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_ID_LIMIT    = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_QUERY_LIMIT = CFG_INDEX_W'(1);

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_ID_BYTE    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_QUERY_BYTE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EMPTY      = 2'd2;
  localparam logic [KIND_W-1:0] KIND_OVERSIZE   = 2'd3;

  typedef logic [BYTE_W-1:0]      byte_t;
  typedef logic [KIND_W-1:0]      kind_t;
  typedef logic [LIMIT_W-1:0]     limit_t;
  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

endpackage

@@ rtl/tlrd_if.sv @@
`timescale 1ns / 1ps

// Raw byte stream channel
interface tlrd_byte_if;
  logic             valid;
  logic             ready;
  tlrd_pkg::byte_t  stream_byte;

  modport source (output valid, output stream_byte, input ready);
  modport sink   (input valid, input stream_byte, output ready);
endinterface

// Parsed result channel
interface tlrd_result_if;
  logic             valid;
  logic             ready;
  tlrd_pkg::kind_t  kind;
  tlrd_pkg::byte_t  payload_byte;
  logic             section_end;
  logic             frame_end;

  modport source (output valid, output kind, output payload_byte, output section_end,
                  output frame_end, input ready);
  modport sink   (input valid, input kind, input payload_byte, input section_end,
                  input frame_end, output ready);
endinterface

// Register write channel
interface tlrd_cfg_if;
  logic                 valid;
  logic                 ready;
  tlrd_pkg::cfg_index_t index;
  tlrd_pkg::limit_t     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/two_length_request_deframer.sv @@
`timescale 1ns / 1ps
// A result is valid in the output register in the cycle after its byte transfer.
// Throughput: one byte per cycle unless a waiting result is held back; the output register
//   frees as it is taken, so a new byte is taken in the same cycle as the waiting result.
// Only the last header byte can give a result; bytes after an error give none.
// Reset (rst, synchronous): header phase, limits to 16 MiB and 64 MiB, output empty.
module two_length_request_deframer #(
  parameter int unsigned LENGTH_BITS = tlrd_pkg::LENGTH_BITS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  tlrd_byte_if.sink         stream,
  tlrd_result_if.source     result,
  tlrd_cfg_if.sink          cfg
);
  import tlrd_pkg::*;

  localparam int unsigned LB = LENGTH_BITS;

  // Phase codes
  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_ID     = 2'd1;
  localparam logic [1:0] PH_QUERY  = 2'd2;
  localparam logic [1:0] PH_ERROR  = 2'd3;

  localparam logic [2:0] HDR_ID_FIRST    = 3'd0;
  localparam logic [2:0] HDR_QUERY_FIRST = 3'd4;
  localparam logic [2:0] HDR_LAST        = 3'd7;

  // State
  logic [1:0]    phase, phase_next;
  logic [2:0]    header_index, header_index_next;
  logic [LB-1:0] id_length, id_length_next;
  logic [LB-1:0] query_length, query_length_next;
  logic          id_ovf, id_ovf_next;
  logic          query_ovf, query_ovf_next;
  logic [LB-1:0] bytes_left, bytes_left_next;
  limit_t        id_limit, query_limit;

  // Output register
  logic   out_valid;
  kind_t  out_kind, kind_next;
  byte_t  out_byte, byte_next;
  logic   out_sec, sec_next;
  logic   out_frm, frm_next;
  logic   res_next;

  logic            in_xfer;
  logic [LB+7:0]   id_shift, query_shift;
  logic            oversize;
  logic            last_byte;
  byte_t           b;

  assign b          = stream.stream_byte;
  assign stream.ready = !out_valid || result.ready;
  assign in_xfer    = stream.valid && stream.ready;
  assign cfg.ready  = 1'b1;

  // Header shift: a length starts from zero on its first byte
  assign id_shift    = {((header_index == HDR_ID_FIRST) ? '0 : id_length), b};
  assign query_shift = {((header_index == HDR_QUERY_FIRST) ? '0 : query_length), b};
  assign last_byte   = (bytes_left[LB-1:1] == '0);

  // Per-byte parse step
  always_comb begin
    phase_next        = phase;
    header_index_next = header_index;
    id_length_next    = id_length;
    query_length_next = query_length;
    id_ovf_next       = id_ovf;
    query_ovf_next    = query_ovf;
    bytes_left_next   = bytes_left;
    res_next          = 1'b0;
    kind_next         = KIND_OVERSIZE;
    byte_next         = '0;
    sec_next          = 1'b0;
    frm_next          = 1'b0;
    oversize          = 1'b0;
    case (phase)
      PH_HEADER: begin
        if (header_index < HDR_QUERY_FIRST) begin
          id_length_next = id_shift[LB-1:0];
          id_ovf_next    = ((header_index == HDR_ID_FIRST) ? 1'b0 : id_ovf) ||
                           (id_shift[LB+7:LB] != '0);
        end else begin
          query_length_next = query_shift[LB-1:0];
          query_ovf_next    = ((header_index == HDR_QUERY_FIRST) ? 1'b0 : query_ovf) ||
                              (query_shift[LB+7:LB] != '0);
        end
        header_index_next = header_index + 3'd1;
        if (header_index == HDR_LAST) begin
          oversize = id_ovf || query_ovf_next ||
                     (LIMIT_W'(id_length) > id_limit) ||
                     (LIMIT_W'(query_length_next) > query_limit);
          if (oversize) begin
            phase_next = PH_ERROR;
            res_next   = 1'b1;
            kind_next  = KIND_OVERSIZE;
          end else if (id_length == '0 && query_length_next == '0) begin
            res_next  = 1'b1;
            kind_next = KIND_EMPTY;
            frm_next  = 1'b1;
          end else if (id_length != '0) begin
            phase_next      = PH_ID;
            bytes_left_next = id_length;
          end else begin
            phase_next      = PH_QUERY;
            bytes_left_next = query_length_next;
          end
        end
      end
      PH_ID, PH_QUERY: begin
        res_next  = 1'b1;
        kind_next = (phase == PH_ID) ? KIND_ID_BYTE : KIND_QUERY_BYTE;
        byte_next = b;
        if (!last_byte) begin
          bytes_left_next = bytes_left - LB'(1);
        end else if (phase == PH_ID && query_length != '0) begin
          phase_next      = PH_QUERY;
          bytes_left_next = query_length;
          sec_next        = 1'b1;
        end else begin
          phase_next      = PH_HEADER;
          bytes_left_next = '0;
          sec_next        = 1'b1;
          frm_next        = 1'b1;
        end
      end
      default: begin
        // error phase: input is dropped
        phase_next = PH_ERROR;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HEADER;
      header_index <= '0;
      id_length    <= '0;
      query_length <= '0;
      id_ovf       <= 1'b0;
      query_ovf    <= 1'b0;
      bytes_left   <= '0;
    end else if (in_xfer) begin
      phase        <= phase_next;
      header_index <= header_index_next;
      id_length    <= id_length_next;
      query_length <= query_length_next;
      id_ovf       <= id_ovf_next;
      query_ovf    <= query_ovf_next;
      bytes_left   <= bytes_left_next;
    end
  end

  // Limit registers
  always_ff @(posedge clk) begin
    if (rst) begin
      id_limit    <= ID_LIMIT_RESET;
      query_limit <= QUERY_LIMIT_RESET;
    end else if (cfg.valid && cfg.ready) begin
      if (cfg.index == REG_ID_LIMIT) begin
        id_limit <= cfg.data;
      end else if (cfg.index == REG_QUERY_LIMIT) begin
        query_limit <= cfg.data;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_xfer && res_next) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && res_next) begin
      out_kind <= kind_next;
      out_byte <= byte_next;
      out_sec  <= sec_next;
      out_frm  <= frm_next;
    end
  end

  assign result.valid        = out_valid;
  assign result.kind         = out_kind;
  assign result.payload_byte = out_byte;
  assign result.section_end  = out_sec;
  assign result.frame_end    = out_frm;

  // Checks
  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    phase == PH_ERROR |=> phase == PH_ERROR)
    else $error("error phase left without reset");

  a_no_result_in_error: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && phase == PH_ERROR) |-> !res_next)
    else $error("result produced after oversize error");

  a_error_result_enters_error: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && res_next && kind_next == KIND_OVERSIZE) |=> phase == PH_ERROR)
    else $error("oversize result without error phase");

  a_payload_count_live: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_ID || phase == PH_QUERY) |-> bytes_left != '0)
    else $error("payload phase with no bytes left");

  a_header_count_phase: assert property (@(posedge clk) disable iff (rst)
    header_index != '0 |-> phase == PH_HEADER)
    else $error("header count running outside header phase");

endmodule
